### design/sc_pkg.sv
// Shared types and constants for the stack calculator.
// No dependencies.
`default_nettype none
package sc_pkg;
  localparam int STACK_DEPTH   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int COUNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0, OP_POP = 3'd1, OP_CLEAR = 3'd2, OP_ADD = 3'd3,
    OP_SUB = 3'd4, OP_MUL = 3'd5, OP_DIV = 3'd6, OP_SUM = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FEW = 2'd1, ST_DIVZERO = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         entry_count;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_LOAD, S_SUM, S_MUL, S_DIV, S_WRITE, S_TOPRD, S_TOPWAIT,
    S_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take_in;     // latch input item
    logic rd_a;        // read entry count-2
    logic rd_b;        // read entry count-1
    logic sum_start;   // clear accumulator, start sum walk
    logic sum_step;    // add one entry
    logic mul_go;      // compute product
    logic div_start;
    logic div_step;
    logic write_res;   // push result
    logic pop;
    logic clear;
    logic rd_top;
    logic latch_top;
    logic set_few;
    logic set_full;
    logic set_divzero;
    logic set_ok;
  } cmd_t;

  typedef struct packed {
    logic [2:0] operation;
    logic       empty;
    logic       few;       // fewer than two entries
    logic       full;
    logic       b_zero;
    logic       walk_end;  // every entry has been read by the sum walk
    logic       sum_done;
    logic       div_done;
  } stat_t;
endpackage
`default_nettype wire

### design/sc_datapath.sv
// Stack memory, accumulator, multiplier and divider of the stack calculator.
// Depends on sc_pkg.
`default_nettype none
module sc_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sc_pkg::in_item_t in_item,
  input  wire sc_pkg::cmd_t     cmd,
  output sc_pkg::stat_t         stat,
  output sc_pkg::out_item_t     out_item
);
  import sc_pkg::*;

  logic [31:0]          mem [STACK_DEPTH];
  logic [31:0]          rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic [COUNT_W-1:0]   count;
  logic [2:0]           operation;
  logic signed [31:0]   push_value;
  logic signed [31:0]   a, b;
  logic signed [63:0]   acc;       // sum accumulator or product
  logic [COUNT_W-1:0]   walk;      // sum walk index
  logic [31:0]          result;
  logic [1:0]           status;
  // Restoring divider on magnitudes.
  logic [63:0]          quo;
  logic [32:0]          rem;
  logic [6:0]           div_cnt;
  logic                 div_neg;
  logic [33:0]          rem_try;
  logic [63:0]          prod;
  logic signed [63:0]   mul_floor;
  logic signed [64:0]   div_signed;
  logic signed [64:0]   res_wide;
  // Sum accumulation uses data read the cycle before; sum_pipe marks it valid.
  logic                 sum_pipe;

  function automatic logic [31:0] sat(input logic signed [64:0] v);
    if (v > 65'sd2147483647)       sat = 32'h7fff_ffff;
    else if (v < -65'sd2147483648) sat = 32'h8000_0000;
    else                           sat = v[31:0];
  endfunction

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_a)         rd_addr = ADDR_W'(count - COUNT_W'(2));
    else if (cmd.sum_step) rd_addr = walk[ADDR_W-1:0];
    else                   rd_addr = ADDR_W'(count - COUNT_W'(1));
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.write_res) mem[count[ADDR_W-1:0]] <= result;
  end

  assign prod      = 64'(a * b);
  assign mul_floor = $signed(prod) >>> FRACTION_BITS;
  assign rem_try   = {rem, quo[63]} - {2'b0, (b[31] ? -b : b)};
  assign div_signed = div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    case (operation)
      OP_ADD:  res_wide = 65'(a) + 65'(b);
      OP_SUB:  res_wide = 65'(a) - 65'(b);
      OP_MUL, OP_SUM: res_wide = 65'(acc);
      OP_DIV:  res_wide = div_signed;
      default: res_wide = 65'(push_value);
    endcase
    result = sat(res_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) sum_pipe <= 1'b0;
    else     sum_pipe <= cmd.sum_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.write_res) count <= count + COUNT_W'(1);
      else if (cmd.pop)  count <= count - COUNT_W'(1);
      else if (cmd.clear) count <= '0;
    end
    if (cmd.take_in) begin
      operation  <= in_item.operation;
      push_value <= in_item.push_value;
    end
    if (cmd.rd_b) a <= rd_data;          // rd_a data arrives in the cycle after rd_a
    if (cmd.latch_top) b <= rd_data;     // operand b after read
    if (cmd.sum_start) begin
      acc  <= '0;
      walk <= '0;
    end else begin
      if (sum_pipe)        acc <= acc + 64'($signed(rd_data));
      else if (cmd.mul_go) acc <= mul_floor;
      if (cmd.sum_step) walk <= walk + COUNT_W'(1);
    end
    if (cmd.div_start) begin
      quo     <= {(a[31] ? 32'(-a) : 32'(a)), 32'b0} >> (32 - FRACTION_BITS);
      rem     <= '0;
      div_cnt <= '0;
      div_neg <= a[31] ^ b[31];
    end else if (cmd.div_step) begin
      if (!rem_try[33]) begin
        rem <= rem_try[32:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[31:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      div_cnt <= div_cnt + 7'd1;
    end else if (cmd.take_in) begin
      div_cnt <= '0;
    end
    if (cmd.set_ok)      status <= ST_OK;
    if (cmd.set_few)     status <= ST_FEW;
    if (cmd.set_full)    status <= ST_FULL;
    if (cmd.set_divzero) status <= ST_DIVZERO;
  end

  // Top value for the result: the entry read after the operation.
  logic [31:0] top_q;
  logic        top_sel;
  always_ff @(posedge clk) begin
    if (cmd.rd_top) top_sel <= 1'b1;
    else            top_sel <= 1'b0;
    if (top_sel) top_q <= (count == '0) ? 32'd0 : rd_data;
  end

  assign stat.operation = operation;
  assign stat.empty     = (count == '0);
  assign stat.few       = (count < COUNT_W'(2));
  assign stat.full      = (count == COUNT_W'(STACK_DEPTH));
  assign stat.b_zero    = (b == '0);
  assign stat.walk_end  = (walk == count);
  assign stat.sum_done  = (walk == count) && !sum_pipe;
  assign stat.div_done  = (div_cnt == 7'd64);

  assign out_item.top_value   = top_q;
  assign out_item.entry_count = 7'(count);
  assign out_item.status      = status;
endmodule
`default_nettype wire

### design/sc_control.sv
// Controller state machine of the stack calculator.
// Depends on sc_pkg.
`default_nettype none
module sc_control (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire sc_pkg::stat_t stat,
  output sc_pkg::cmd_t       cmd
);
  import sc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_RD_A;
      S_RD_A: begin
        case (stat.operation)
          OP_PUSH: state_next = stat.full ? S_TOPRD : S_WRITE;
          OP_POP, OP_CLEAR: state_next = S_TOPRD;
          OP_SUM:  state_next = stat.full ? S_TOPRD : S_SUM;
          default: state_next = stat.few ? S_TOPRD : S_RD_B;
        endcase
      end
      S_RD_B: state_next = S_LOAD;
      S_LOAD: begin
        case (stat.operation)
          OP_MUL:  state_next = S_MUL;
          OP_DIV:  state_next = S_DIV;
          default: state_next = stat.full ? S_TOPRD : S_WRITE;
        endcase
      end
      S_MUL:  state_next = stat.full ? S_TOPRD : S_WRITE;
      S_SUM:  if (stat.sum_done) state_next = S_WRITE;
      S_DIV: begin
        if (stat.b_zero) state_next = S_TOPRD;
        else if (stat.div_done) state_next = stat.full ? S_TOPRD : S_WRITE;
      end
      S_WRITE:   state_next = S_TOPRD;
      S_TOPRD:   state_next = S_TOPWAIT;
      S_TOPWAIT: state_next = S_OUT;
      S_OUT:     if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Division steps only after the start cycle; div_started marks that.
  logic div_started;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_started <= 1'b0;
    end else begin
      div_started <= (state == S_DIV) && !stat.div_done;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: cmd.take_in = in_valid;
      S_RD_A: begin
        cmd.rd_a   = 1'b1;
        cmd.set_ok = 1'b1;
        case (stat.operation)
          OP_PUSH: cmd.set_full = stat.full;
          OP_POP: begin
            cmd.pop     = !stat.empty;
            cmd.set_few = stat.empty;
          end
          OP_CLEAR: cmd.clear = 1'b1;
          OP_SUM: begin
            cmd.set_full  = stat.full;
            cmd.sum_start = 1'b1;
          end
          default: cmd.set_few = stat.few;
        endcase
      end
      S_RD_B: cmd.rd_b = 1'b1;
      S_LOAD: begin
        cmd.latch_top = 1'b1;
        if (stat.operation != OP_MUL && stat.operation != OP_DIV)
          cmd.set_full = stat.full;
      end
      S_MUL: begin
        cmd.mul_go   = 1'b1;
        cmd.set_full = stat.full;
      end
      S_SUM: cmd.sum_step = !stat.walk_end;
      S_DIV: begin
        if (stat.b_zero) begin
          cmd.pop         = 1'b1;
          cmd.set_divzero = 1'b1;
        end else if (!div_started && !stat.div_done) begin
          cmd.div_start = 1'b1;
        end else if (!stat.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.set_full = stat.full;
        end
      end
      S_WRITE: cmd.write_res = 1'b1;
      S_TOPRD: cmd.rd_top = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### design/stack_calculator.sv
// Top level of the stack calculator: controller plus datapath.
// Depends on sc_pkg, sc_control and sc_datapath.
//
// The stack calculator holds up to 64 signed Q16.16 values and runs one
// operation per transaction: push, pop, clear, add, subtract, multiply,
// divide or sum-all. Binary operations keep their operands and push the
// result, except that a divide by zero pops the divisor and pushes nothing;
// all results saturate to 32 bits. Each transaction returns exactly one
// result transaction with the new top, the entry count and a status. Work
// is one item at a time. A binary operation reads and loads its operands,
// computes (a multiply state, or for divide a start step, 64 restoring
// quotient steps and a finishing step) and writes the result; every
// operation ends by reading the new top and offering the result. Sum-all
// walks the held entries one by one through the stack memory's single
// read port. A result refused on a full stack skips the write cycle. A
// receiver stall holds the result offered until it is taken.
// The stack memory needs no clearing pass after reset.
`default_nettype none
module stack_calculator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sc_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sc_pkg::out_item_t      out_data
);
  import sc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each transaction; the datapath does the work.
  sc_control u_control (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  sc_datapath u_datapath (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .out_item(out_data)
  );
endmodule
`default_nettype wire
